/* hw/rtl/csort_pkg.sv */
package csort_pkg;

    // Sizing
    localparam int MAX_VALUE = 15;
    localparam int MAX_ITEMS = 64;
    localparam int NUM_BINS  = MAX_VALUE + 1;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 4;

    // Input transfer
    typedef struct packed {
        logic [VAL_W-1:0] sample_value;
        logic             final_item;
    } sort_in_t;

    // Output transfer
    typedef struct packed {
        logic [VAL_W-1:0] sorted_value;
        logic             run_end;
        logic             overflowed;
    } sort_out_t;

    // Bin memory access group
    typedef struct packed {
        logic [BIN_W-1:0] rd_addr;
        logic             wr_en;
        logic [BIN_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
    } ram_req_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_DRAIN = 6'b000010,
        ST_READ  = 6'b000100,
        ST_LATCH = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_MARK  = 6'b100000
    } state_t;

endpackage

/* hw/rtl/csort_bin_ram.sv */
module csort_bin_ram
    import csort_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ram_req_t         req,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0]    mem [NUM_BINS];
    logic [NUM_BINS-1:0] valid_reg;
    logic [CNT_W-1:0]    rd_q_reg;
    logic                rd_valid_reg;

    // Storage array, read-before-write, registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_q_reg <= mem[req.rd_addr];
    end

    // Per-bin valid bits: an unwritten bin reads as zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[req.rd_addr];
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

/* hw/rtl/counting_sort_engine.sv */
// Load: one item per cycle; each item's bin is read, then incremented and written back from
// the increment stage, with forwarding when consecutive items hit the same bin.
// After the final item: drain, then for each bin read, latch and clear, and emit its
// count, advancing bin by bin until the last counted item is out; results leave one per
// cycle during a bin's emit state, via an output register. An empty set emits a marker.
// Reset (async, active low) clears all counts, item count and overflow mark; no receiver stall.
module counting_sort_engine
    import csort_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  sort_in_t  item,
    output logic      result_valid,
    output sort_out_t result
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic             ovf_reg, ovf_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic             out_valid_reg, out_valid_next;
    sort_out_t        out_item_reg, out_item_next;

    // Increment stage
    logic             upd_valid_reg, upd_valid_next;
    logic [BIN_W-1:0] upd_addr_reg;

    // Last write, for forwarding
    logic             lw_valid_reg;
    logic [BIN_W-1:0] lw_addr_reg;
    logic [CNT_W-1:0] lw_data_reg;

    ram_req_t         req;
    logic [CNT_W-1:0] rd_data;
    logic [CNT_W-1:0] upd_base;
    logic             accept;
    logic             countable;
    logic             last_one;

    csort_bin_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    assign busy      = (state_reg != ST_LOAD);
    assign accept    = start && !busy;
    assign countable = (32'(item.sample_value) <= MAX_VALUE)
                    && (32'(loaded_reg) < MAX_ITEMS);
    assign last_one  = (CNT_W'(emit_cnt_reg + 1'b1) == loaded_reg);

    // Forward the previous write when it hit the bin being incremented
    assign upd_base = (lw_valid_reg && (lw_addr_reg == upd_addr_reg)) ? lw_data_reg : rd_data;

    // Memory port steering
    always_comb
    begin
        req.rd_addr = (state_reg == ST_LOAD) ? item.sample_value[BIN_W-1:0] : bin_reg;
        req.wr_en   = 1'b0;
        req.wr_addr = upd_addr_reg;
        req.wr_data = CNT_W'(upd_base + 1'b1);
        if (upd_valid_reg)
        begin
            req.wr_en = 1'b1;
        end
        else if (state_reg == ST_LATCH)
        begin
            req.wr_en   = 1'b1;
            req.wr_addr = bin_reg;
            req.wr_data = '0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        ovf_next       = ovf_reg;
        bin_next       = bin_reg;
        remain_next    = remain_reg;
        emit_cnt_next  = emit_cnt_reg;
        upd_valid_next = 1'b0;
        out_valid_next = 1'b0;
        out_item_next  = out_item_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (countable)
                    begin
                        upd_valid_next = 1'b1;
                        loaded_next    = CNT_W'(loaded_reg + 1'b1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.final_item)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // final increment lands this cycle
                bin_next      = '0;
                emit_cnt_next = '0;
                state_next    = (loaded_reg == '0) ? ST_MARK : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                // capture count and clear the bin
                remain_next = rd_data;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (remain_reg != '0)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.sorted_value = VAL_W'(bin_reg);
                    out_item_next.run_end      = last_one;
                    out_item_next.overflowed   = ovf_reg;
                    remain_next                = CNT_W'(remain_reg - 1'b1);
                    emit_cnt_next              = CNT_W'(emit_cnt_reg + 1'b1);
                    if (last_one)
                    begin
                        // remaining bins are already zero
                        loaded_next = '0;
                        ovf_next    = 1'b0;
                        state_next  = ST_LOAD;
                    end
                end
                else if (32'(bin_reg) == NUM_BINS - 1)
                begin
                    loaded_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_LOAD;
                end
                else
                begin
                    bin_next   = BIN_W'(bin_reg + 1'b1);
                    state_next = ST_READ;
                end
            end
            ST_MARK:
            begin
                // empty set marker
                out_valid_next             = 1'b1;
                out_item_next.sorted_value = '0;
                out_item_next.run_end      = 1'b1;
                out_item_next.overflowed   = ovf_reg;
                loaded_next                = '0;
                ovf_next                   = 1'b0;
                state_next                 = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            loaded_reg    <= '0;
            ovf_reg       <= 1'b0;
            bin_reg       <= '0;
            remain_reg    <= '0;
            emit_cnt_reg  <= '0;
            upd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            ovf_reg       <= ovf_next;
            bin_reg       <= bin_next;
            remain_reg    <= remain_next;
            emit_cnt_reg  <= emit_cnt_next;
            upd_valid_reg <= upd_valid_next;
            out_valid_reg <= out_valid_next;
            lw_valid_reg  <= req.wr_en;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        upd_addr_reg <= item.sample_value[BIN_W-1:0];
        lw_addr_reg  <= req.wr_addr;
        lw_data_reg  <= req.wr_data;
        out_item_reg <= out_item_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
